>>> rtl/yfsl_pkg.sv
// ----------------------------------------------------------------------------
// yfsl_pkg
// Shared types and constants for the yaw-follow slew limiter.
// ----------------------------------------------------------------------------
package yfsl_pkg;

	localparam int TimeW   = 24;
	localparam int AngleW  = 16;
	localparam int ElapsW  = 16;
	localparam int RateW   = 16;
	localparam int CfgIdxW = 2;
	localparam int CfgDatW = 24;

	// register indexes on the configuration channel
	localparam logic [CfgIdxW-1:0] REG_IDLE_DELAY = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_REV_COOL   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_SLEW_RATE  = 2'd2;

	// reset values of the registers
	localparam logic [TimeW-1:0] IDLE_DELAY_RST = 24'd32768;
	localparam logic [TimeW-1:0] REV_COOL_RST   = 24'd16384;
	localparam logic [RateW-1:0] SLEW_RATE_RST  = 16'd16384;

	// turn direction codes, two's complement
	localparam logic [1:0] SIGN_NONE = 2'b00;
	localparam logic [1:0] SIGN_POS  = 2'b01;
	localparam logic [1:0] SIGN_NEG  = 2'b11;

	localparam logic [AngleW-1:0] TURN_QUARTER = 16'd16384;
	localparam logic [AngleW-1:0] TURN_HALF    = 16'd32768;

	typedef struct packed {
		logic [TimeW-1:0] idle_delay;
		logic [TimeW-1:0] reversal_cooldown;
		logic [RateW-1:0] slew_rate;
	} cfg_t;

	typedef struct packed {
		logic [ElapsW-1:0] elapsed;
		logic [AngleW-1:0] target_heading;
		logic [AngleW-1:0] view_heading;
		logic              target_valid;
		logic              aiming;
		logic              manual_turn;
	} item_t;

endpackage

>>> rtl/yfsl_if.sv
// ----------------------------------------------------------------------------
// yfsl_if
// Valid/ready channels: input item, result and configuration write.
// ----------------------------------------------------------------------------
interface yfsl_item_if;
	logic        valid;
	logic        ready;
	logic [15:0] elapsed;
	logic [15:0] target_heading;
	logic [15:0] view_heading;
	logic        target_valid;
	logic        aiming;
	logic        manual_turn;

	modport source (output valid, elapsed, target_heading, view_heading,
		target_valid, aiming, manual_turn, input ready);
	modport sink (input valid, elapsed, target_heading, view_heading,
		target_valid, aiming, manual_turn, output ready);
endinterface

interface yfsl_result_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] yaw_adjust;

	modport source (output valid, yaw_adjust, input ready);
	modport sink (input valid, yaw_adjust, output ready);
endinterface

interface yfsl_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/yaw_follow_slew_limiter_top.sv
// ----------------------------------------------------------------------------
// yaw_follow_slew_limiter_top
// Path: an item taken on the input channel goes through the input register
// (stage 1) and then the result register before it shows on the output channel.
// Throughput: one item per cycle while the result channel is not stalled; the
// single 16x16 multiply and the timer compares sit between those two registers.
// Reset: arst_n clears timers, direction and pipeline valids and restores
// the register defaults; no clearing pass, the block is ready at once.
// ----------------------------------------------------------------------------
module yaw_follow_slew_limiter_top (
	input  logic          clk,
	input  logic          arst_n,
	yfsl_item_if.sink     item,
	yfsl_result_if.source result,
	yfsl_cfg_if.sink      cfg
);
	import yfsl_pkg::*;

	cfg_t              cfg_val;
	item_t             item_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic [AngleW-1:0] yaw_q;
	logic [AngleW-1:0] yaw_nxt;
	logic              advance;

	// Configuration writes never stall.
	assign cfg.ready = 1'b1;

	yfsl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_val)
	);

	// Advance the item in stage 1 when the result register is free or
	// being drained this cycle; the tick state updates at the same edge.
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// Hold the payload while stage 1 stalls.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.elapsed        <= item.elapsed;
			item_s1.target_heading <= item.target_heading;
			item_s1.view_heading   <= item.view_heading;
			item_s1.target_valid   <= item.target_valid;
			item_s1.aiming         <= item.aiming;
			item_s1.manual_turn    <= item.manual_turn;
		end
	end

	yfsl_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_val),
		.item       (item_s1),
		.advance    (advance),
		.yaw_adjust (yaw_nxt)
	);

	// Result register: load on advance, drop valid once transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			yaw_q <= yaw_nxt;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.yaw_adjust = yaw_q;

endmodule

>>> rtl/yfsl_cfg.sv
// ----------------------------------------------------------------------------
// yfsl_cfg
// Configuration register file; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module yfsl_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [yfsl_pkg::CfgIdxW-1:0] wr_index,
	input  logic [yfsl_pkg::CfgDatW-1:0] wr_data,
	output yfsl_pkg::cfg_t              cfg
);
	import yfsl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_delay        <= IDLE_DELAY_RST;
			cfg_q.reversal_cooldown <= REV_COOL_RST;
			cfg_q.slew_rate         <= SLEW_RATE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_IDLE_DELAY: cfg_q.idle_delay        <= wr_data;
				REG_REV_COOL:   cfg_q.reversal_cooldown <= wr_data;
				REG_SLEW_RATE:  cfg_q.slew_rate         <= wr_data[RateW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/yfsl_step.sv
// ----------------------------------------------------------------------------
// yfsl_step
// Per-tick follow logic and the timer / direction state it updates.
// ----------------------------------------------------------------------------
module yfsl_step (
	input  logic                     clk,
	input  logic                     arst_n,
	input  yfsl_pkg::cfg_t           cfg,
	input  yfsl_pkg::item_t          item,
	input  logic                     advance,
	output logic [yfsl_pkg::AngleW-1:0] yaw_adjust
);
	import yfsl_pkg::*;

	logic [TimeW-1:0] idle_left_q;
	logic [TimeW-1:0] cooldown_left_q;
	logic [1:0]       last_sign_q;

	logic [TimeW-1:0]  elapsed_ext;
	logic [TimeW-1:0]  cool_dec;
	logic [TimeW-1:0]  idle_dec;
	logic [TimeW-1:0]  idle_nxt;
	logic [TimeW-1:0]  cool_nxt;
	logic [1:0]        sign_nxt;
	logic [AngleW-1:0] raw;
	logic [AngleW-1:0] mag;
	logic [1:0]        sign;
	logic [31:0]       prod;
	logic [31:0]       scaled;
	logic [AngleW-1:0] step;
	logic [AngleW-1:0] result;

	assign elapsed_ext = {{(TimeW-ElapsW){1'b0}}, item.elapsed};
	assign cool_dec = (cooldown_left_q > elapsed_ext) ? cooldown_left_q - elapsed_ext : '0;
	assign idle_dec = (idle_left_q > elapsed_ext) ? idle_left_q - elapsed_ext : '0;

	assign raw  = item.target_heading - item.view_heading;
	assign prod = {16'd0, cfg.slew_rate} * {16'd0, item.elapsed};
	assign scaled = {mag, 16'd0};

	always_comb begin
		if (raw == '0) begin
			sign = SIGN_NONE;
			mag  = '0;
		end else if (raw <= TURN_HALF) begin
			sign = SIGN_POS;
			mag  = raw;
		end else begin
			sign = SIGN_NEG;
			mag  = '0 - raw;
		end
	end

	always_comb begin
		idle_nxt = idle_dec;
		cool_nxt = cool_dec;
		sign_nxt = last_sign_q;
		result   = '0;
		step     = '0;
		if (item.target_valid && !item.aiming) begin
			if (item.manual_turn) begin
				idle_nxt = cfg.idle_delay;
			end
			if (idle_nxt == '0 && !(sign != last_sign_q && cool_dec != '0)) begin
				if (sign != last_sign_q) begin
					sign_nxt = sign;
					cool_nxt = cfg.reversal_cooldown;
				end
				if (mag <= TURN_QUARTER) begin
					if (sign != SIGN_NONE && scaled < prod) begin
						// overshoot: land exactly and start a lockout
						sign_nxt = SIGN_NONE;
						cool_nxt = cfg.reversal_cooldown;
						step     = mag;
					end else if (sign != SIGN_NONE) begin
						step = prod[31:16];
					end
					result = (sign == SIGN_NEG) ? ('0 - step) : step;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_left_q     <= '0;
			cooldown_left_q <= '0;
			last_sign_q     <= SIGN_NONE;
		end else if (advance) begin
			idle_left_q     <= idle_nxt;
			cooldown_left_q <= cool_nxt;
			last_sign_q     <= sign_nxt;
		end
	end

	assign yaw_adjust = result;

endmodule
